// ----- hdl/contiguous_frame_allocator_macros.svh -----
// assertion macros for the frame allocator
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH

`define CFA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: label failed");

`define CFA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: label failed");

`endif

// ----- hdl/cfa_pkg.sv -----
package cfa_pkg;

    localparam int FRAME_W = 20;
    localparam int CNT_W   = 11;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_REL   = 2'd2,
        OP_MARK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADREL  = 2'd2,
        ST_BADMARK = 2'd3
    } t_status;

    localparam logic [1:0] FS_FREE  = 2'd0;
    localparam logic [1:0] FS_USED  = 2'd1;
    localparam logic [1:0] FS_HEAD  = 2'd2;
    localparam logic [1:0] FS_INACC = 2'd3;

    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_POOL    = 2'd1;
    localparam logic [1:0] REG_RESERVE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_SCAN_W,
        S_WRITE,
        S_REL_RD,
        S_REL_W,
        S_REL_CHK,
        S_MK_RD,
        S_MK_W,
        S_MK_CHK,
        S_MK_WR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;      // latch item, reset pointers
        logic       clr_ptr;   // pointer back to zero
        logic       clr_wr;    // init entry at pointer, advance
        logic       rd;        // read map at pointer
        logic       scan_step; // consume read data in alloc scan
        logic       alloc_ptr; // pointer to run start
        logic       alloc_wr;  // write head/used at pointer
        logic       rel_ptr;   // pointer to release offset
        logic       rel_wr;    // free at pointer and advance
        logic       mk_ptr;    // pointer to mark offset
        logic       mk_adv;    // advance pointer in mark check
        logic       mk_wr;     // write inaccessible and advance
        logic       init_cnt;  // load free count for init
        logic [1:0] st;        // status to return
        logic       ok_alloc;  // return first frame
        logic       done;      // drive result strobe
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        t_op        in_op;     // op at the input port
        t_op        op;
        logic       ptr_last;  // pointer at last entry of its range
        logic       ptr_end;   // pointer past pool end
        logic       zero_cnt;
        logic       cnt_over;  // count above free count
        logic       found;     // run of count free frames seen
        logic       rd_free;
        logic       rd_used;
        logic       rd_head;
        logic       rel_bad;   // release address out of pool
        logic       mk_bad;    // mark range out of pool
        logic       wr_last;   // last write of alloc/mark run
    } t_sts;

endpackage

// ----- hdl/contiguous_frame_allocator.sv -----
// one operation at a time; init, allocate, release and mark each step through
// the frame map entry by entry; in the release loop one map entry is read while
// the entry before it is written
// reset (synchronous, active low) loads register defaults, then a clearing
// pass runs an init with busy high and no result strobe
// results show for one cycle on o_done; the receiver cannot stall
module contiguous_frame_allocator #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic [cfa_pkg::FRAME_W-1:0] i_frame_no,
    input  logic [cfa_pkg::CNT_W-1:0]   i_count,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [cfa_pkg::FRAME_W-1:0] i_cfg_data,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [cfa_pkg::FRAME_W-1:0] o_first_frame,
    output logic [cfa_pkg::CNT_W-1:0]   o_free_frames
);

    logic [cfa_pkg::FRAME_W-1:0] r_base;
    logic [cfa_pkg::CNT_W-1:0]   r_pool;
    logic                        r_reserve;
    logic                        r_boot;
    cfa_pkg::t_ctl               w_ctl;
    cfa_pkg::t_sts               w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_pool    <= cfa_pkg::CNT_W'(1024);
            r_reserve <= 1'b1;
            r_boot    <= 1'b1;
        end else begin
            if (w_ctl.done) begin
                r_boot <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfa_pkg::REG_BASE:    r_base    <= i_cfg_data;
                    cfa_pkg::REG_POOL:    r_pool    <= i_cfg_data[cfa_pkg::CNT_W-1:0];
                    cfa_pkg::REG_RESERVE: r_reserve <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    cfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    cfa_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_op          (i_op),
        .i_frame_no    (i_frame_no),
        .i_count       (i_count),
        .i_base        (r_base),
        .i_pool        (r_pool),
        .i_reserve     (r_reserve),
        .o_sts         (w_sts),
        .o_status      (o_status),
        .o_first_frame (o_first_frame),
        .o_free_frames (o_free_frames)
    );

    assign o_done = w_ctl.done && !r_boot;

endmodule

// ----- hdl/cfa_ctrl.sv -----
module cfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  cfa_pkg::t_sts i_sts,
    output cfa_pkg::t_ctl o_ctl,
    output logic          o_busy
);

    cfa_pkg::t_state r_state, n_state;
    logic [1:0] r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::S_CLEAR;
            r_st    <= cfa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        case (r_state)
            cfa_pkg::S_IDLE: begin
                if (i_go) begin
                    n_st = cfa_pkg::ST_OK;
                    case (i_sts.in_op)
                        cfa_pkg::OP_INIT:  n_state = cfa_pkg::S_CLEAR;
                        cfa_pkg::OP_ALLOC: n_state = cfa_pkg::S_SCAN;
                        cfa_pkg::OP_REL:   n_state = cfa_pkg::S_REL_RD;
                        default:           n_state = cfa_pkg::S_MK_RD;
                    endcase
                end
            end
            cfa_pkg::S_CLEAR: begin
                if (i_sts.ptr_last) begin
                    n_state = cfa_pkg::S_DONE;
                end
            end
            cfa_pkg::S_SCAN: begin
                if (i_sts.zero_cnt || i_sts.cnt_over || i_sts.ptr_end) begin
                    n_st    = cfa_pkg::ST_NOSPACE;
                    n_state = cfa_pkg::S_DONE;
                end else begin
                    n_state = cfa_pkg::S_SCAN_W;
                end
            end
            cfa_pkg::S_SCAN_W: begin
                if (i_sts.found) begin
                    n_state = cfa_pkg::S_WRITE;
                end else if (i_sts.ptr_end) begin
                    n_st    = cfa_pkg::ST_NOSPACE;
                    n_state = cfa_pkg::S_DONE;
                end else begin
                    n_state = cfa_pkg::S_SCAN_W;
                end
            end
            cfa_pkg::S_WRITE: begin
                if (i_sts.wr_last) begin
                    n_state = cfa_pkg::S_DONE;
                end
            end
            cfa_pkg::S_REL_RD: begin
                if (i_sts.rel_bad) begin
                    n_st    = cfa_pkg::ST_BADREL;
                    n_state = cfa_pkg::S_DONE;
                end else begin
                    n_state = cfa_pkg::S_REL_W;
                end
            end
            cfa_pkg::S_REL_W: begin
                if (!i_sts.rd_head) begin
                    n_st    = cfa_pkg::ST_BADREL;
                    n_state = cfa_pkg::S_DONE;
                end else begin
                    n_state = cfa_pkg::S_REL_CHK;
                end
            end
            cfa_pkg::S_REL_CHK: begin
                if (i_sts.ptr_end || !i_sts.rd_used) begin
                    n_state = cfa_pkg::S_DONE;
                end
            end
            cfa_pkg::S_MK_RD: begin
                if (i_sts.zero_cnt) begin
                    n_state = cfa_pkg::S_DONE;
                end else if (i_sts.mk_bad) begin
                    n_st    = cfa_pkg::ST_BADMARK;
                    n_state = cfa_pkg::S_DONE;
                end else begin
                    n_state = cfa_pkg::S_MK_W;
                end
            end
            cfa_pkg::S_MK_W: begin
                n_state = cfa_pkg::S_MK_CHK;
            end
            cfa_pkg::S_MK_CHK: begin
                if (!i_sts.rd_free) begin
                    n_st    = cfa_pkg::ST_BADMARK;
                    n_state = cfa_pkg::S_DONE;
                end else if (i_sts.wr_last) begin
                    n_state = cfa_pkg::S_MK_WR;
                end
            end
            cfa_pkg::S_MK_WR: begin
                if (i_sts.wr_last) begin
                    n_state = cfa_pkg::S_DONE;
                end
            end
            cfa_pkg::S_DONE: n_state = cfa_pkg::S_IDLE;
            default:         n_state = cfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl    = '0;
        o_ctl.st = r_st;
        o_busy   = (r_state != cfa_pkg::S_IDLE);
        case (r_state)
            cfa_pkg::S_IDLE: begin
                o_ctl.load = i_go;
            end
            cfa_pkg::S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                o_ctl.init_cnt = i_sts.ptr_last;
            end
            cfa_pkg::S_SCAN: begin
                o_ctl.rd = 1'b1;
            end
            cfa_pkg::S_SCAN_W: begin
                o_ctl.scan_step = 1'b1;
                o_ctl.rd        = 1'b1;
                o_ctl.alloc_ptr = i_sts.found;
            end
            cfa_pkg::S_WRITE: begin
                o_ctl.alloc_wr = 1'b1;
            end
            cfa_pkg::S_REL_RD: begin
                o_ctl.rel_ptr = 1'b1;
            end
            cfa_pkg::S_REL_W: begin
                o_ctl.rel_wr = i_sts.rd_head;
            end
            cfa_pkg::S_REL_CHK: begin
                o_ctl.rel_wr = !i_sts.ptr_end && i_sts.rd_used;
            end
            cfa_pkg::S_MK_RD: begin
                o_ctl.mk_ptr = 1'b1;
            end
            cfa_pkg::S_MK_CHK: begin
                o_ctl.mk_adv = i_sts.rd_free;
                o_ctl.mk_ptr = i_sts.rd_free && i_sts.wr_last;
            end
            cfa_pkg::S_MK_WR: begin
                o_ctl.mk_wr = 1'b1;
            end
            cfa_pkg::S_DONE: begin
                o_ctl.done     = 1'b1;
                o_ctl.ok_alloc = (i_sts.op == cfa_pkg::OP_ALLOC) &&
                                 (r_st == cfa_pkg::ST_OK);
                o_ctl.clr_ptr  = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/cfa_dp.sv -----
module cfa_dp #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfa_pkg::t_ctl               i_ctl,
    input  logic [1:0]                  i_op,
    input  logic [cfa_pkg::FRAME_W-1:0] i_frame_no,
    input  logic [cfa_pkg::CNT_W-1:0]   i_count,
    input  logic [cfa_pkg::FRAME_W-1:0] i_base,
    input  logic [cfa_pkg::CNT_W-1:0]   i_pool,
    input  logic                        i_reserve,
    output cfa_pkg::t_sts               o_sts,
    output logic [1:0]                  o_status,
    output logic [cfa_pkg::FRAME_W-1:0] o_first_frame,
    output logic [cfa_pkg::CNT_W-1:0]   o_free_frames
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int PW = AW + 1;
    localparam int WW = (PW > cfa_pkg::FRAME_W + 1) ? PW : cfa_pkg::FRAME_W + 1;

    logic [1:0] r_mem [MAX_FRAMES];
    logic [1:0] r_rd;

    logic [1:0]                  r_op;
    logic [cfa_pkg::FRAME_W-1:0] r_fno;
    logic [cfa_pkg::CNT_W-1:0]   r_cnt;
    logic [PW-1:0]               r_ptr, r_start, r_run, r_end;
    logic [PW-1:0]               r_lim;
    logic [cfa_pkg::CNT_W-1:0]   r_free;
    logic [cfa_pkg::CNT_W-1:0]   r_tally;
    logic [PW-1:0]               w_n;
    logic [WW-1:0]               w_off, w_cntx, w_nx;
    logic                        w_rd_free;
    logic [PW-1:0]               w_run_nx;
    logic [AW-1:0]               w_rd_addr;

    function automatic logic [cfa_pkg::CNT_W-1:0] CNT_FIT(input logic [PW-1:0] v);
        logic [WW-1:0] t;
        t = WW'(v);
        return t[cfa_pkg::CNT_W-1:0];
    endfunction

    // effective pool size, capped at the map depth
    always_comb begin
        if ({{(WW-cfa_pkg::CNT_W){1'b0}}, i_pool} > WW'(MAX_FRAMES)) begin
            w_n = PW'(MAX_FRAMES);
        end else begin
            w_n = PW'(i_pool);
        end
        w_off  = WW'(r_fno) - WW'(i_base);
        w_cntx = WW'(r_cnt);
        w_nx   = WW'(w_n);
    end

    // read address follows the pointer value that release and mark move to
    always_comb begin
        if (i_ctl.rel_ptr || i_ctl.mk_ptr) begin
            w_rd_addr = w_off[AW-1:0];
        end else if (i_ctl.rel_wr || i_ctl.mk_adv) begin
            w_rd_addr = r_ptr[AW-1:0] + AW'(1);
        end else begin
            w_rd_addr = r_ptr[AW-1:0];
        end
    end

    assign w_rd_free = (r_rd == cfa_pkg::FS_FREE);
    assign w_run_nx  = w_rd_free ? r_run + PW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd || i_ctl.rel_ptr || i_ctl.mk_ptr || i_ctl.mk_adv ||
            i_ctl.rel_wr) begin
            r_rd <= r_mem[w_rd_addr];
        end
        if (i_ctl.clr_wr) begin
            r_mem[r_ptr[AW-1:0]] <= (r_ptr == '0 && i_reserve && w_n != '0) ?
                                    cfa_pkg::FS_USED : cfa_pkg::FS_FREE;
        end else if (i_ctl.alloc_wr) begin
            r_mem[r_ptr[AW-1:0]] <= (r_ptr == r_start) ?
                                    cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
        end else if (i_ctl.rel_wr) begin
            r_mem[r_ptr[AW-1:0]] <= cfa_pkg::FS_FREE;
        end else if (i_ctl.mk_wr) begin
            r_mem[r_ptr[AW-1:0]] <= cfa_pkg::FS_INACC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_op    <= cfa_pkg::OP_INIT;
            r_free  <= '0;
            r_run   <= '0;
            r_tally <= '0;
        end else begin
            if (i_ctl.load) begin
                r_op    <= i_op;
                r_fno   <= i_frame_no;
                r_cnt   <= i_count;
                r_ptr   <= '0;
                r_run   <= '0;
                r_tally <= '0;
            end
            if (i_ctl.clr_ptr) begin
                r_ptr <= '0;
            end
            if (i_ctl.clr_wr) begin
                r_ptr <= r_ptr + PW'(1);
            end
            if (i_ctl.init_cnt) begin
                r_free <= (i_reserve && w_n != '0) ? CNT_FIT(w_n - PW'(1)) : CNT_FIT(w_n);
            end
            if (i_ctl.rd && !i_ctl.alloc_ptr) begin
                r_ptr <= r_ptr + PW'(1);
            end
            if (i_ctl.scan_step) begin
                r_run <= w_run_nx;
                if (w_rd_free && r_run == '0) begin
                    r_start <= r_ptr - PW'(1);
                end
            end
            if (i_ctl.alloc_ptr) begin
                r_ptr <= (r_run == '0) ? r_ptr - PW'(1) : r_start;
                r_end <= ((r_run == '0) ? r_ptr - PW'(1) : r_start) + PW'(r_cnt) - PW'(1);
            end
            if (i_ctl.alloc_wr) begin
                r_ptr <= r_ptr + PW'(1);
                if (r_ptr == r_end) begin
                    r_free <= r_free - r_cnt;
                end
            end
            if (i_ctl.rel_ptr) begin
                r_ptr <= w_off[PW-1:0];
            end
            if (i_ctl.rel_wr) begin
                r_ptr   <= r_ptr + PW'(1);
                r_free  <= (r_free == {cfa_pkg::CNT_W{1'b1}}) ? r_free : r_free + 1'b1;
            end
            if (i_ctl.mk_ptr) begin
                r_ptr <= w_off[PW-1:0];
                r_end <= w_off[PW-1:0] + PW'(r_cnt) - PW'(1);
            end
            if (i_ctl.mk_adv && !i_ctl.mk_ptr) begin
                r_ptr <= r_ptr + PW'(1);
            end
            if (i_ctl.mk_wr) begin
                r_ptr  <= r_ptr + PW'(1);
                r_free <= (r_free == '0) ? r_free : r_free - 1'b1;
            end
        end
    end

    assign r_lim = w_n;

    always_comb begin
        o_sts          = '0;
        o_sts.in_op    = cfa_pkg::t_op'(i_op);
        o_sts.op       = cfa_pkg::t_op'(r_op);
        o_sts.ptr_last = (r_ptr == PW'(MAX_FRAMES - 1));
        o_sts.ptr_end  = (r_ptr >= r_lim);
        o_sts.zero_cnt = (r_cnt == '0);
        o_sts.cnt_over = (r_cnt > r_free);
        o_sts.found    = (w_run_nx == PW'(r_cnt)) && (r_ptr <= r_lim);
        o_sts.rd_free  = w_rd_free;
        o_sts.rd_used  = (r_rd == cfa_pkg::FS_USED);
        o_sts.rd_head  = (r_rd == cfa_pkg::FS_HEAD);
        o_sts.rel_bad  = (r_fno < i_base) || (w_off >= w_nx);
        o_sts.mk_bad   = (r_fno < i_base) || (w_off >= w_nx) || (w_cntx > w_nx - w_off);
        o_sts.wr_last  = (r_ptr == r_end);
    end

    assign o_status      = i_ctl.st;
    assign o_first_frame = i_ctl.ok_alloc ? i_base + cfa_pkg::FRAME_W'(r_start) : '0;
    assign o_free_frames = r_free;

endmodule

// ----- hdl/cfa_checker.sv -----
`include "contiguous_frame_allocator_macros.svh"

module cfa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [1:0]                  o_status,
    input logic [cfa_pkg::FRAME_W-1:0] o_first_frame
);

    `CFA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `CFA_ASSERT_IMPL(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `CFA_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy && !o_done)
    `CFA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_done && o_status != cfa_pkg::ST_OK, o_first_frame == '0)

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_first_frame (o_first_frame)
);
